/* hdl/ansi_text_console_macros.svh */
// Assertion shorthands for the console, clocked on aclk, off while in reset.
`ifndef ANSI_TEXT_CONSOLE_MACROS_SVH
`define ANSI_TEXT_CONSOLE_MACROS_SVH

`define ATC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define ATC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/atc_pkg.sv */
`default_nettype none
package atc_pkg;

    localparam int MAX_COLS_DEF  = 128;
    localparam int MAX_ROWS_DEF  = 64;
    localparam int ARG_SLOTS_DEF = 8;
    localparam int TAB_STOP_DEF  = 8;

    localparam logic [7:0] COLS_RST = 8'd80;
    localparam logic [6:0] ROWS_RST = 7'd25;
    localparam logic [6:0] ATTR_RST = 7'd7;

    localparam logic [1:0] CFG_COLUMNS      = 2'd0;
    localparam logic [1:0] CFG_ROWS         = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_ATTR = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CUP   = 8'h48;
    localparam logic [7:0] CH_ED    = 8'h4A;
    localparam logic [7:0] CH_EL    = 8'h4B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SGR   = 8'h6D;

    localparam logic [15:0] SGR_RESET  = 16'd0;
    localparam logic [15:0] SGR_BRIGHT = 16'd1;
    localparam logic [15:0] SGR_FG_LO  = 16'd30;
    localparam logic [15:0] SGR_FG_HI  = 16'd37;
    localparam logic [15:0] SGR_BG_LO  = 16'd40;
    localparam logic [15:0] SGR_BG_HI  = 16'd47;

    localparam logic [15:0] ERASE_TO_END    = 16'd0;
    localparam logic [15:0] ERASE_TO_CURSOR = 16'd1;
    localparam logic [15:0] ERASE_ALL       = 16'd2;

    typedef enum logic [1:0] {PS_GROUND, PS_ESC, PS_PARAM} parse_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ, ST_TABMOD, ST_GLYPH,
        ST_SCROLL, ST_SCROLL_END, ST_ERASE, ST_SGR, ST_DONE
    } state_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_in;
        logic [6:0] read_col;
        logic [5:0] read_row;
    } atc_in_t;

    typedef struct packed {
        logic [7:0] cursor_col;
        logic [5:0] cursor_row;
        logic [7:0] cell_char;
        logic [2:0] cell_fg;
        logic [2:0] cell_bg;
        logic       cell_bright;
    } atc_out_t;

endpackage
`default_nettype wire

/* hdl/ansi_text_console.sv */
// Character-cell text console fed by a byte stream. Each request word gives one
// result word: a byte request returns the cursor after the byte, a read request
// the cursor and one cell. The screen lives in one synchronous cell RAM of
// MAX_ROWS x MAX_COLS entries (rounded up to powers of two). After reset the RAM
// is swept to spaces, one cell a cycle (8192 cells at the default size), and no
// request is taken until it ends; configuration writes are taken throughout.
// A TAB first steps its column down by whole tab stops and then writes one space
// per cell up to the next stop; SGR applies its arguments one by one. A scroll
// walks the RAM one cell a cycle and then blanks the last row, and erase blanks
// its cells row by row. A result held back by m_ready blocks the next request;
// s_ready rises again with m_valid.
`default_nettype none
`include "ansi_text_console_macros.svh"
module ansi_text_console #(
    parameter int MAX_COLS  = atc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = atc_pkg::MAX_ROWS_DEF,
    parameter int ARG_SLOTS = atc_pkg::ARG_SLOTS_DEF,
    parameter int TAB_STOP  = atc_pkg::TAB_STOP_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire atc_pkg::atc_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output atc_pkg::atc_out_t     m_data
);
    import atc_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CX_W   = COL_W + 1;
    localparam int H_W    = ROW_W + 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int IDX_W  = $clog2(ARG_SLOTS);
    localparam int CNT_W  = $clog2(ARG_SLOTS + 1);
    localparam int TAB_W  = $clog2(TAB_STOP + 1);

    state_t state_reg, state_next;
    parse_t ps_reg, ps_next;
    logic [7:0] cols_reg, cols_next;
    logic [6:0] rows_reg, rows_next;
    logic [6:0] dattr_reg, dattr_next;
    logic [6:0] attr_reg, attr_next;
    logic [CX_W-1:0] cx_reg, cx_next;
    logic [ROW_W-1:0] cy_reg, cy_next;
    atc_in_t req_reg, req_next;
    logic [15:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0] slot_reg [ARG_SLOTS];
    logic [15:0] slot_next [ARG_SLOTS];
    logic [CNT_W-1:0] sgr_i_reg, sgr_i_next;
    logic [TAB_W-1:0] left_reg, left_next;
    logic [7:0] gch_reg, gch_next;
    logic [CX_W-1:0] rem_reg, rem_next;
    logic ret_glyph_reg, ret_glyph_next;
    logic [ROW_W-1:0] sr_reg, sr_next;
    logic [CX_W-1:0] sc_reg, sc_next;
    logic [ROW_W-1:0] er_row_reg, er_row_next, end_row_reg, end_row_next;
    logic [CX_W-1:0] er_col_reg, er_col_next, end_col_reg, end_col_next;
    logic wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [14:0] cell_reg, cell_next;
    atc_out_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    logic [14:0] cell_mem [DEPTH];
    logic [14:0] rdata_reg;
    logic mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [14:0] mem_wdata;

    logic [CX_W-1:0] w_used, w_m1, xc;
    logic [H_W-1:0] h_used;
    logic [ROW_W-1:0] h_m1;
    logic [7:0] ch;
    logic [19:0] acc_mul;
    logic [15:0] eff0, eff1, rv, cv, sv;
    logic in_store, do_put, nl_go;

    always_comb begin
        if (cols_reg == 8'd0) begin
            w_used = CX_W'(1);
        end else if (32'(cols_reg) > MAX_COLS) begin
            w_used = CX_W'(MAX_COLS);
        end else begin
            w_used = CX_W'(cols_reg);
        end
        if (rows_reg == 7'd0) begin
            h_used = H_W'(1);
        end else if (32'(rows_reg) > MAX_ROWS) begin
            h_used = H_W'(MAX_ROWS);
        end else begin
            h_used = H_W'(rows_reg);
        end
    end

    assign w_m1 = w_used - CX_W'(1);
    assign h_m1 = ROW_W'(h_used - H_W'(1));
    assign xc = (cx_reg < w_m1) ? cx_reg : w_m1;
    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    always_comb begin
        state_next = state_reg;
        ps_next = ps_reg;
        cols_next = cols_reg;
        rows_next = rows_reg;
        dattr_next = dattr_reg;
        attr_next = attr_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        req_next = req_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        slot_next = slot_reg;
        sgr_i_next = sgr_i_reg;
        left_next = left_reg;
        gch_next = gch_reg;
        rem_next = rem_reg;
        ret_glyph_next = ret_glyph_reg;
        sr_next = sr_reg;
        sc_next = sc_reg;
        er_row_next = er_row_reg;
        er_col_next = er_col_reg;
        end_row_next = end_row_reg;
        end_col_next = end_col_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        clr_next = clr_reg;
        cell_next = cell_reg;
        out_next = out_reg;
        m_valid_next = m_valid_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re = 1'b0;
        mem_raddr = '0;
        ch = req_reg.byte_in;
        do_put = 1'b0;
        nl_go = 1'b0;
        in_store = (32'(req_reg.read_col) < MAX_COLS) && (32'(req_reg.read_row) < MAX_ROWS);
        acc_mul = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + 20'(ch - CH_0);
        eff0 = (cnt_reg == CNT_W'(0)) ? acc_reg : slot_reg[0];
        eff1 = (cnt_reg == CNT_W'(1)) ? acc_reg : slot_reg[1];
        rv = (eff0 == 16'd0) ? 16'd0 : eff0 - 16'd1;
        cv = (cnt_reg == CNT_W'(0) || eff1 == 16'd0) ? 16'd0 : eff1 - 16'd1;
        sv = slot_reg[sgr_i_reg[IDX_W-1:0]];

        if (cfg_valid) begin
            case (cfg_index)
                CFG_COLUMNS:      cols_next = cfg_data;
                CFG_ROWS:         rows_next = cfg_data[6:0];
                CFG_DEFAULT_ATTR: dattr_next = cfg_data[6:0];
                default:          ;
            endcase
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {ATTR_RST, CH_SPACE};
                clr_next = clr_reg + ADDR_W'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    cx_next = (cx_reg > w_used) ? w_used : cx_reg;
                    cy_next = (32'(cy_reg) >= 32'(h_used)) ? h_m1 : cy_reg;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cell_next = '0;
                if (req_reg.req_type) begin
                    mem_re = 1'b1;
                    mem_raddr = {ROW_W'(req_reg.read_row), COL_W'(req_reg.read_col)};
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DONE;
                    case (ps_reg)
                        PS_GROUND: begin
                            if (ch == CH_ESC) begin
                                ps_next = PS_ESC;
                                cnt_next = '0;
                                acc_next = '0;
                            end else begin
                                do_put = 1'b1;
                            end
                        end
                        PS_ESC: begin
                            ps_next = PS_GROUND;
                            if (ch == CH_LBR) begin
                                ps_next = PS_PARAM;
                            end else begin
                                do_put = 1'b1;
                            end
                        end
                        default: begin
                            if (ch >= CH_0 && ch <= CH_9) begin
                                acc_next = (acc_mul > 20'hFFFF) ? 16'hFFFF : acc_mul[15:0];
                            end else begin
                                if (32'(cnt_reg) < ARG_SLOTS) begin
                                    slot_next[cnt_reg[IDX_W-1:0]] = acc_reg;
                                    cnt_next = cnt_reg + CNT_W'(1);
                                end
                                acc_next = '0;
                                if (ch != CH_SEMI) begin
                                    ps_next = PS_GROUND;
                                    if (ch == CH_CUP) begin
                                        cy_next = (32'(rv) < 32'(h_m1)) ? ROW_W'(rv) : h_m1;
                                        cx_next = (32'(cv) < 32'(w_m1)) ? CX_W'(cv) : w_m1;
                                    end else if (ch == CH_SGR) begin
                                        sgr_i_next = '0;
                                        state_next = ST_SGR;
                                    end else if (ch == CH_ED || ch == CH_EL) begin
                                        ret_glyph_next = 1'b0;
                                        state_next = ST_ERASE;
                                        er_row_next = cy_reg;
                                        er_col_next = '0;
                                        end_row_next = cy_reg;
                                        end_col_next = w_m1;
                                        if (eff0 == ERASE_TO_END) begin
                                            er_col_next = cx_reg;
                                            if (ch == CH_ED) begin
                                                end_row_next = h_m1;
                                            end
                                        end else if (eff0 == ERASE_TO_CURSOR) begin
                                            end_col_next = xc;
                                            if (ch == CH_ED) begin
                                                er_row_next = '0;
                                            end
                                        end else if (eff0 == ERASE_ALL) begin
                                            if (ch == CH_ED) begin
                                                er_row_next = '0;
                                                end_row_next = h_m1;
                                            end
                                        end else begin
                                            state_next = ST_DONE;
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                    if (do_put) begin
                        case (ch)
                            CH_LF: begin
                                nl_go = 1'b1;
                                ret_glyph_next = 1'b0;
                            end
                            CH_CR: cx_next = '0;
                            CH_TAB: begin
                                rem_next = cx_reg;
                                state_next = ST_TABMOD;
                            end
                            CH_BS: begin
                                if (cx_reg != '0) begin
                                    cx_next = cx_reg - CX_W'(1);
                                end else if (cy_reg != '0) begin
                                    cy_next = cy_reg - ROW_W'(1);
                                    cx_next = w_m1;
                                end
                            end
                            default: begin
                                left_next = TAB_W'(1);
                                gch_next = ch;
                                state_next = ST_GLYPH;
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                cell_next = in_store ? rdata_reg : '0;
                state_next = ST_DONE;
            end
            ST_TABMOD: begin
                if (32'(rem_reg) >= TAB_STOP) begin
                    rem_next = rem_reg - CX_W'(TAB_STOP);
                end else begin
                    left_next = TAB_W'(TAB_STOP - 32'(rem_reg));
                    gch_next = CH_SPACE;
                    state_next = ST_GLYPH;
                end
            end
            ST_GLYPH: begin
                if (left_reg == '0) begin
                    state_next = ST_DONE;
                end else if (cx_reg >= w_used) begin
                    nl_go = 1'b1;
                    ret_glyph_next = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = {cy_reg, cx_reg[COL_W-1:0]};
                    mem_wdata = {attr_reg, gch_reg};
                    cx_next = cx_reg + CX_W'(1);
                    left_next = left_reg - TAB_W'(1);
                end
            end
            ST_SCROLL: begin
                mem_re = 1'b1;
                mem_raddr = {sr_reg + ROW_W'(1), sc_reg[COL_W-1:0]};
                mem_we = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = rdata_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = {sr_reg, sc_reg[COL_W-1:0]};
                if (sc_reg + CX_W'(1) == w_used) begin
                    sc_next = '0;
                    if (sr_reg + ROW_W'(1) == h_m1) begin
                        state_next = ST_SCROLL_END;
                    end else begin
                        sr_next = sr_reg + ROW_W'(1);
                    end
                end else begin
                    sc_next = sc_reg + CX_W'(1);
                end
            end
            ST_SCROLL_END: begin
                mem_we = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = rdata_reg;
                er_row_next = h_m1;
                er_col_next = '0;
                end_row_next = h_m1;
                end_col_next = w_m1;
                state_next = ST_ERASE;
            end
            ST_ERASE: begin
                if (er_row_reg > end_row_reg) begin
                    state_next = ret_glyph_reg ? ST_GLYPH : ST_DONE;
                end else if (er_col_reg >= w_used
                             || (er_row_reg == end_row_reg && er_col_reg > end_col_reg)) begin
                    if (er_row_reg == end_row_reg) begin
                        state_next = ret_glyph_reg ? ST_GLYPH : ST_DONE;
                    end else begin
                        er_row_next = er_row_reg + ROW_W'(1);
                        er_col_next = '0;
                    end
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = {er_row_reg, er_col_reg[COL_W-1:0]};
                    mem_wdata = {dattr_reg, CH_SPACE};
                    er_col_next = er_col_reg + CX_W'(1);
                end
            end
            ST_SGR: begin
                if (sgr_i_reg == cnt_reg) begin
                    state_next = ST_DONE;
                end else begin
                    sgr_i_next = sgr_i_reg + CNT_W'(1);
                    if (sv == SGR_RESET) begin
                        attr_next = dattr_reg;
                    end else if (sv == SGR_BRIGHT) begin
                        attr_next = attr_reg | 7'h40;
                    end else if (sv >= SGR_FG_LO && sv <= SGR_FG_HI) begin
                        attr_next = {attr_reg[6:3], 3'(sv - SGR_FG_LO)};
                    end else if (sv >= SGR_BG_LO && sv <= SGR_BG_HI) begin
                        attr_next = {attr_reg[6], 3'(sv - SGR_BG_LO), attr_reg[2:0]};
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.cursor_col = 8'(cx_reg);
                    out_next.cursor_row = 6'(cy_reg);
                    out_next.cell_char = cell_reg[7:0];
                    out_next.cell_fg = cell_reg[10:8];
                    out_next.cell_bg = cell_reg[13:11];
                    out_next.cell_bright = cell_reg[14];
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // new line: scroll when already on the last row, or erase that row on a one-row screen
        if (nl_go) begin
            cx_next = '0;
            if (32'(cy_reg) + 1 < 32'(h_used)) begin
                cy_next = cy_reg + ROW_W'(1);
                state_next = ret_glyph_next ? ST_GLYPH : ST_DONE;
            end else if (h_used >= H_W'(2)) begin
                sr_next = '0;
                sc_next = '0;
                state_next = ST_SCROLL;
            end else begin
                er_row_next = h_m1;
                er_col_next = '0;
                end_row_next = h_m1;
                end_col_next = w_m1;
                state_next = ST_ERASE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= cell_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ps_reg <= PS_GROUND;
            cols_reg <= COLS_RST;
            rows_reg <= ROWS_RST;
            dattr_reg <= ATTR_RST;
            attr_reg <= ATTR_RST;
            cx_reg <= '0;
            cy_reg <= '0;
            cnt_reg <= '0;
            clr_reg <= '0;
            wr_pend_reg <= 1'b0;
            ret_glyph_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ps_reg <= ps_next;
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            dattr_reg <= dattr_next;
            attr_reg <= attr_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
            wr_pend_reg <= wr_pend_next;
            ret_glyph_reg <= ret_glyph_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg <= req_next;
        acc_reg <= acc_next;
        slot_reg <= slot_next;
        sgr_i_reg <= sgr_i_next;
        left_reg <= left_next;
        gch_reg <= gch_next;
        rem_reg <= rem_next;
        sr_reg <= sr_next;
        sc_reg <= sc_next;
        er_row_reg <= er_row_next;
        er_col_reg <= er_col_next;
        end_row_reg <= end_row_next;
        end_col_reg <= end_col_next;
        wr_addr_reg <= wr_addr_next;
        cell_reg <= cell_next;
        out_reg <= out_next;
    end

    `ATC_ASSERT_IMP(a_no_accept_clear, state_reg == ST_CLEAR, !s_ready, "word taken during clear")
    `ATC_ASSERT_IMP(a_glyph_in_row, state_reg == ST_GLYPH && mem_we, cx_reg < w_used, "glyph past row")
    `ATC_ASSERT_IMP(a_row_in_use, state_reg != ST_IDLE, {1'b0, cy_reg} < h_used, "row out of range")
    `ATC_ASSERT_NEXT(a_done_emits, state_reg == ST_DONE && !m_valid_reg, m_valid_reg, "result word lost")

endmodule
`default_nettype wire

/* dv/ansi_text_console_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module ansi_text_console_tb;
    import atc_pkg::*;

    localparam int W_MAX = 128;
    localparam int H_MAX = 64;
    localparam int ARGS = 8;
    localparam int TABW = 8;
    localparam int STALL_LIMIT = 60000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_COLUMNS;
    logic [7:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    atc_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    atc_out_t m_data;

    ansi_text_console dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // screen shadow
    logic [7:0] cols_q = COLS_RST;
    logic [6:0] rows_q = ROWS_RST;
    logic [6:0] dflt_attr = ATTR_RST;
    logic [14:0] screen [H_MAX][W_MAX];
    int unsigned cur_x, cur_y;
    logic [6:0] pen_attr;
    parse_t esc_state;
    logic [15:0] arg_val [ARGS+1];
    bit arg_void [ARGS+1];
    int unsigned arg_n;

    atc_out_t cursor_words [$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int cfg_writes = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int idle_cnt = 0;

    function automatic int unsigned scr_w();
        return (cols_q == 0) ? 1 : ((cols_q > W_MAX) ? W_MAX : cols_q);
    endfunction

    function automatic int unsigned scr_h();
        return (rows_q == 0) ? 1 : ((rows_q > H_MAX) ? H_MAX : rows_q);
    endfunction

    function automatic void blank_span(int unsigned r, int unsigned c0, int unsigned c1);
        if (r >= H_MAX) return;
        if (c1 > W_MAX) c1 = W_MAX;
        for (int unsigned c = c0; c < c1; c++) screen[r][c] = {dflt_attr, CH_SPACE};
    endfunction

    function automatic void line_feed();
        int unsigned w = scr_w();
        int unsigned h = scr_h();
        cur_x = 0;
        cur_y++;
        if (cur_y >= h) begin
            for (int unsigned r = 0; r + 1 < h; r++)
                for (int unsigned c = 0; c < w; c++) screen[r][c] = screen[r+1][c];
            blank_span(h - 1, 0, w);
            cur_y = h - 1;
        end
    endfunction

    function automatic void draw_glyph(logic [7:0] ch);
        if (cur_x >= scr_w()) line_feed();
        screen[cur_y][cur_x] = {pen_attr, ch};
        cur_x++;
    endfunction

    function automatic void plain_byte(logic [7:0] ch);
        int unsigned n;
        case (ch)
            CH_LF: line_feed();
            CH_CR: cur_x = 0;
            CH_TAB: begin
                n = TABW - (cur_x % TABW);
                repeat (n) draw_glyph(CH_SPACE);
            end
            CH_BS: begin
                if (cur_x > 0) cur_x--;
                else if (cur_y > 0) begin
                    cur_y--;
                    cur_x = scr_w() - 1;
                end
            end
            default: draw_glyph(ch);
        endcase
    endfunction

    function automatic int unsigned arg_at(int unsigned i);
        if (i > ARGS || arg_void[i]) return 0;
        return arg_val[i];
    endfunction

    function automatic void move_cursor();
        int unsigned r = arg_at(0);
        int unsigned c = (arg_n >= 2) ? arg_at(1) : 0;
        if (r == 0) r = 1;
        if (c == 0) c = 1;
        cur_y = (r - 1 < scr_h() - 1) ? r - 1 : scr_h() - 1;
        cur_x = (c - 1 < scr_w() - 1) ? c - 1 : scr_w() - 1;
    endfunction

    function automatic void erase(bit whole);
        int unsigned w = scr_w();
        int unsigned h = scr_h();
        int unsigned mode = arg_at(0);
        int unsigned xc = (cur_x < w - 1) ? cur_x : w - 1;
        if (mode == ERASE_TO_END) begin
            blank_span(cur_y, cur_x, w);
            if (whole) for (int unsigned r = cur_y + 1; r < h; r++) blank_span(r, 0, w);
        end else if (mode == ERASE_TO_CURSOR) begin
            if (whole) for (int unsigned r = 0; r < cur_y; r++) blank_span(r, 0, w);
            blank_span(cur_y, 0, xc + 1);
        end else if (mode == ERASE_ALL) begin
            if (whole) for (int unsigned r = 0; r < h; r++) blank_span(r, 0, w);
            else blank_span(cur_y, 0, w);
        end
    endfunction

    function automatic void set_rendition();
        int unsigned v;
        for (int unsigned i = 0; i < arg_n && i <= ARGS; i++) begin
            v = arg_at(i);
            if (v == SGR_RESET) pen_attr = dflt_attr;
            else if (v == SGR_BRIGHT) pen_attr[6] = 1'b1;
            else if (v >= SGR_FG_LO && v <= SGR_FG_HI) pen_attr[2:0] = 3'(v - SGR_FG_LO);
            else if (v >= SGR_BG_LO && v <= SGR_BG_HI) pen_attr[5:3] = 3'(v - SGR_BG_LO);
        end
    endfunction

    function automatic void feed_byte(logic [7:0] ch);
        int unsigned v;
        if (esc_state == PS_GROUND) begin
            if (ch == CH_ESC) begin
                esc_state = PS_ESC;
                arg_n = 0;
                arg_val[0] = 0;
                arg_void[0] = 1'b1;
            end else plain_byte(ch);
        end else if (esc_state == PS_ESC) begin
            esc_state = PS_GROUND;
            if (ch == CH_LBR) esc_state = PS_PARAM;
            else plain_byte(ch);
        end else begin
            if (arg_n > ARGS) arg_n = ARGS;
            if (ch >= CH_0 && ch <= CH_9) begin
                v = arg_val[arg_n] * 10 + (ch - CH_0);
                arg_val[arg_n] = (v > 16'hFFFF) ? 16'hFFFF : 16'(v);
                arg_void[arg_n] = 1'b0;
            end else begin
                if (arg_n < ARGS) arg_n++;
                arg_val[arg_n] = 0;
                arg_void[arg_n] = 1'b1;
                if (ch != CH_SEMI) begin
                    case (ch)
                        CH_CUP: move_cursor();
                        CH_ED: erase(1'b1);
                        CH_EL: erase(1'b0);
                        CH_SGR: set_rendition();
                        default: ;
                    endcase
                    esc_state = PS_GROUND;
                end
            end
        end
    endfunction

    function automatic atc_out_t console_step(atc_in_t w);
        atc_out_t o = '0;
        logic [14:0] scr_cell;
        if (cur_y >= scr_h()) cur_y = scr_h() - 1;
        if (cur_x > scr_w()) cur_x = scr_w();
        if (!w.req_type) feed_byte(w.byte_in);
        else begin
            scr_cell = screen[w.read_row][w.read_col];
            o.cell_char = scr_cell[7:0];
            o.cell_fg = scr_cell[10:8];
            o.cell_bg = scr_cell[13:11];
            o.cell_bright = scr_cell[14];
        end
        o.cursor_col = cur_x[7:0];
        o.cursor_row = cur_y[5:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch on word %0d: got %0d, expected %0d",
                 $time, what, words_out, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        atc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (cursor_words.size() == 0) report_mismatch("unexpected word", 1, 0);
            else begin
                want = cursor_words.pop_front();
                if (m_data.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", m_data.cursor_col, want.cursor_col);
                if (m_data.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", m_data.cursor_row, want.cursor_row);
                if (m_data.cell_char !== want.cell_char)
                    report_mismatch("cell_char", m_data.cell_char, want.cell_char);
                if (m_data.cell_fg !== want.cell_fg)
                    report_mismatch("cell_fg", m_data.cell_fg, want.cell_fg);
                if (m_data.cell_bg !== want.cell_bg)
                    report_mismatch("cell_bg", m_data.cell_bg, want.cell_bg);
                if (m_data.cell_bright !== want.cell_bright)
                    report_mismatch("cell_bright", m_data.cell_bright, want.cell_bright);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(logic rt, logic [7:0] b, logic [6:0] c, logic [5:0] r);
        atc_in_t w;
        w.req_type = rt;
        w.byte_in = b;
        w.read_col = c;
        w.read_row = r;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        cursor_words.push_back(console_step(w));
        words_in++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(1'b0, b, 7'($urandom_range(127)), 6'($urandom_range(63)));
    endtask

    task automatic send_read(logic [6:0] c, logic [5:0] r);
        send_word(1'b1, 8'($urandom_range(255)), c, r);
    endtask

    task automatic send_csi(string params, logic [7:0] fin);
        send_byte(CH_ESC);
        send_byte(CH_LBR);
        for (int i = 0; i < params.len(); i++) send_byte(params[i]);
        send_byte(fin);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        wait (cursor_words.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_COLUMNS: cols_q = d;
            CFG_ROWS: rows_q = d[6:0];
            CFG_DEFAULT_ATTR: dflt_attr = d[6:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_screen(logic [7:0] c, logic [6:0] r, logic [6:0] a);
        wait_idle();
        write_reg(CFG_COLUMNS, c);
        write_reg(CFG_ROWS, {1'b0, r});
        write_reg(CFG_DEFAULT_ATTR, {1'b0, a});
    endtask

    task automatic test_reset_screen();
        send_read(0, 0);
        send_read(7'd127, 6'd63);
    endtask

    task automatic test_text_controls();
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_byte(CH_LF);
        send_byte(CH_BS);
        send_byte(CH_CR);
        send_read(0, 0);
    endtask

    task automatic test_escape_sequences();
        send_byte(CH_ESC);
        send_byte(8'h5A);
        send_csi("2;5", CH_CUP);
        send_csi(";", CH_CUP);
        send_csi("1;31;42", CH_SGR);
        send_byte(8'h7E);
        send_csi("", CH_SGR);
        send_csi("1", CH_EL);
        send_csi("99999", CH_ED);
        send_csi("", CH_ED);
        send_csi("3", CH_ESC);
        send_read(1, 0);
    endtask

    task automatic test_screen_extremes();
        set_screen(8'd255, 7'd127, 7'd127);
        send_csi("999;999", CH_CUP);
        send_byte(8'h5A);
        send_byte(8'h5A);
        send_read(7'd127, 6'd63);
        set_screen(8'd0, 7'd0, 7'd0);
        send_byte(8'h31);
        send_byte(8'h32);
        send_byte(CH_LF);
        send_read(0, 0);
        set_screen(COLS_RST, ROWS_RST, ATTR_RST);
    endtask

    task automatic random_sequence();
        string params;
        int nargs;
        int sel;
        logic [7:0] fin;
        params = "";
        nargs = $urandom_range(0, 11);
        for (int i = 0; i < nargs; i++) begin
            if (i > 0) params = {params, ";"};
            sel = $urandom_range(9);
            if (sel == 0) ;
            else if (sel == 1) params = {params, "0"};
            else if (sel == 2) params = {params, $sformatf("%0d", $urandom_range(30, 37))};
            else if (sel == 3) params = {params, $sformatf("%0d", $urandom_range(40, 47))};
            else if (sel == 4) params = {params, $sformatf("%0d", $urandom_range(1, 2))};
            else if (sel == 5) params = {params, $sformatf("%0d", $urandom_range(65530, 999999))};
            else params = {params, $sformatf("%0d", $urandom_range(3, 150))};
        end
        sel = $urandom_range(11);
        case (sel)
            0, 1, 2: fin = CH_CUP;
            3: fin = CH_ED;
            4, 5: fin = CH_EL;
            6, 7, 8: fin = CH_SGR;
            9: fin = CH_ESC;
            default: fin = 8'($urandom_range(255));
        endcase
        send_csi(params, fin);
    endtask

    task automatic test_random_stream(int n);
        int start = words_in;
        int k;
        while (words_in - start < n) begin
            k = $urandom_range(99);
            if (k < 30) random_sequence();
            else if (k < 48) begin
                if ($urandom_range(3) == 0)
                    send_read(7'($urandom_range(127)), 6'($urandom_range(63)));
                else
                    send_read(7'($urandom_range(scr_w() - 1)), 6'($urandom_range(scr_h() - 1)));
            end else if (k < 58) begin
                case ($urandom_range(3))
                    0: send_byte(CH_CR);
                    1: send_byte(CH_LF);
                    2: send_byte(CH_TAB);
                    default: send_byte(CH_BS);
                endcase
            end else if (k < 63) begin
                send_byte(CH_ESC);
                send_byte(8'($urandom_range(255)));
            end else send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 34 : ((ph == 1) ? 53 : 0);
            stall_pct = (ph == 0) ? 53 : ((ph == 1) ? 34 : 0);
            for (int blk = 0; blk < 5; blk++) begin
                if (ph == 0 && blk == 0) begin
                    set_screen(8'd128, 7'd64, 7'($urandom_range(127)));
                    test_random_stream(60);
                end else begin
                    set_screen(8'($urandom_range(1, 24)), 7'($urandom_range(1, 8)),
                               7'($urandom_range(127)));
                    test_random_stream(125);
                end
            end
        end
    endtask

    initial begin
        for (int r = 0; r < H_MAX; r++)
            for (int c = 0; c < W_MAX; c++) screen[r][c] = {ATTR_RST, CH_SPACE};
        cur_x = 0;
        cur_y = 0;
        pen_attr = ATTR_RST;
        esc_state = PS_GROUND;
        arg_n = 0;
        for (int i = 0; i <= ARGS; i++) begin
            arg_val[i] = '0;
            arg_void[i] = 1'b1;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_screen();
        test_text_controls();
        test_escape_sequences();
        test_screen_extremes();
        test_random_phases();
        wait_idle();
        repeat (100) @(posedge aclk);
        $display("Covered %0d request words, %0d result words, %0d register writes,",
                 words_in, words_out, cfg_writes);
        $display("screen sizes from 1x1 to full, escape sequences, scrolls and reads.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
